/* rtl/core/hpr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpr_pkg
// Shared types, constants and the CRC-32C byte update for the hash router.
// ----------------------------------------------------------------------------
package hpr_pkg;

  localparam int unsigned TABLE_SLOTS_DEF = 64;
  localparam int unsigned EXT_W           = 13;  // holds any slot count up to 4096

  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [1:0]  CFG_ADDR_ENTRIES = 2'd0;

  typedef logic [63:0] boundary_t;
  typedef logic [15:0] tag_t;
  typedef logic [31:0] crc_t;

  function automatic crc_t crc32c_byte(input crc_t crc_in, input logic [7:0] data);
    crc_t c;
    c = crc_in ^ {24'd0, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* rtl/core/hpr_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpr_table
// Boundary and tag storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module hpr_table #(
  parameter int unsigned TABLE_SLOTS = hpr_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_addr,
  input  hpr_pkg::boundary_t  wr_bnd,
  input  hpr_pkg::tag_t       wr_tag,
  input  logic [IDX_W-1:0]    rd_addr,
  output hpr_pkg::boundary_t  rd_bnd,
  output hpr_pkg::tag_t       rd_tag
);
  import hpr_pkg::*;

  boundary_t bnd_mem [TABLE_SLOTS];
  tag_t      tag_mem [TABLE_SLOTS];
  boundary_t rd_bnd_r;
  tag_t      rd_tag_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bnd_mem[wr_addr] <= wr_bnd;
      tag_mem[wr_addr] <= wr_tag;
    end
  end

  always_ff @(posedge clk) begin
    rd_bnd_r <= bnd_mem[rd_addr];
    rd_tag_r <= tag_mem[rd_addr];
  end

  assign rd_bnd = rd_bnd_r;
  assign rd_tag = rd_tag_r;

endmodule

/* rtl/core/hash_partition_router_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_partition_router_core
// CRC-32C key hashing and upper-bound binary search over a boundary table.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall  | kind, slot, boundary, tag, key byte, flags
//  out_    | output    | out_valid / out_stall| found, slot, owner tag, key hash
//  cfg     | APB r/w   | psel/penable/pwrite  | entries_in_use at address 0
//
//  Load beats and non-final key beats leave the core idle, so no stall follows them.
//  A final key beat runs the search: each probe passes S_RD and S_CMP, up to
//  ceil(log2(n+1)) probes, then S_FIN (tag read) and S_RES (result load).
//  The table memory read port sets the probe rate.
//  Reset clears control state and the CRC; table contents stay undefined.
//  in_stall is high while a search runs or the result waits for the output register.
// ----------------------------------------------------------------------------
module hash_partition_router_core #(
  parameter int unsigned TABLE_SLOTS = hpr_pkg::TABLE_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic [5:0]         in_slot_index,
  input  hpr_pkg::boundary_t in_boundary_value,
  input  hpr_pkg::tag_t      in_partition_tag,
  input  logic [7:0]         in_key_byte,
  input  logic               in_byte_present,
  input  logic               in_last_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_found,
  output logic [5:0]         out_slot_found,
  output hpr_pkg::tag_t      out_owner_tag,
  output hpr_pkg::boundary_t out_key_hash,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import hpr_pkg::*;

  localparam int unsigned IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_SLOTS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_RES  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [6:0]       entries_r;
  crc_t             crc_r, crc_nxt, crc_upd;
  boundary_t        hash_r, hash_nxt;
  logic [CNT_W-1:0] first_r, first_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] step;
  logic [CNT_W-1:0] probe;
  logic [EXT_W-1:0] ent_ext;
  logic [EXT_W-1:0] slot_ext;
  logic [EXT_W-1:0] first_ext;
  logic             in_acc;
  logic             wr_en;
  logic             found;
  boundary_t        rd_bnd;
  tag_t             rd_tag;

  logic             out_valid_r;
  logic             out_found_r;
  logic [5:0]       out_slot_r;
  tag_t             out_tag_r;
  boundary_t        out_hash_r;
  logic             out_load;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr == CFG_ADDR_ENTRIES) ? {25'd0, entries_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= 7'd0;
    end else if (psel && penable && pwrite) begin
      entries_r <= pwdata[6:0];
    end
  end

  // input side
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign slot_ext = EXT_W'(in_slot_index);
  assign wr_en    = in_acc && !in_kind && (slot_ext < EXT_W'(TABLE_SLOTS));
  assign ent_ext  = EXT_W'(entries_r);

  assign crc_upd = in_byte_present ? crc32c_byte(crc_r, in_key_byte) : crc_r;

  assign step  = count_r >> 1;
  assign probe = first_r + step;

  hpr_table #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .IDX_W       (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot_ext[IDX_W-1:0]),
    .wr_bnd  (in_boundary_value),
    .wr_tag  (in_partition_tag),
    .rd_addr (probe[IDX_W-1:0]),
    .rd_bnd  (rd_bnd),
    .rd_tag  (rd_tag)
  );

  assign first_ext = EXT_W'(first_r);
  assign found     = (first_r < n_r);
  assign out_load  = (state_r == S_RES) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    crc_nxt   = crc_r;
    hash_nxt  = hash_r;
    first_nxt = first_r;
    count_nxt = count_r;
    n_nxt     = n_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_kind) begin
          crc_nxt = crc_upd;
          if (in_last_byte) begin
            crc_nxt   = CRC_INIT;
            hash_nxt  = {~crc_upd, ~crc_upd};
            n_nxt     = (ent_ext > EXT_W'(TABLE_SLOTS)) ? CNT_W'(TABLE_SLOTS)
                                                        : CNT_W'(ent_ext);
            first_nxt = '0;
            count_nxt = n_nxt;
            state_nxt = (n_nxt == '0) ? S_FIN : S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (rd_bnd <= hash_r) begin
          first_nxt = probe + CNT_W'(1);
          count_nxt = count_r - step - CNT_W'(1);
        end else begin
          count_nxt = step;
        end
        state_nxt = (count_nxt == '0) ? S_FIN : S_RD;
      end
      S_FIN: begin
        state_nxt = S_RES;
      end
      S_RES: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      crc_r   <= CRC_INIT;
    end else begin
      state_r <= state_nxt;
      crc_r   <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hash_r  <= hash_nxt;
    first_r <= first_nxt;
    count_r <= count_nxt;
    n_r     <= n_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found_r <= found;
      out_slot_r  <= found ? first_ext[5:0] : 6'd0;
      out_tag_r   <= found ? rd_tag : '0;
      out_hash_r  <= hash_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_slot_found = out_slot_r;
  assign out_owner_tag  = out_tag_r;
  assign out_key_hash   = out_hash_r;

endmodule

/* tb/hash_partition_router_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_partition_router_core_tb
// Self-checking bench for the hash partition router. Streams table loads and
// partition keys with random burst gaps and output stalls, predicts each
// route (CRC-32C hash, upper-bound search over the boundary table) and checks
// every result beat field by field. Sweeps entries_in_use over the APB port.
// ----------------------------------------------------------------------------
module hash_partition_router_core_tb;

  localparam logic       KIND_LOAD          = 1'b0;
  localparam logic       KIND_KEY           = 1'b1;
  localparam logic [1:0] REG_ENTRIES_IN_USE = 2'd0;
  localparam int         NUM_SLOTS          = 64;
  localparam logic [31:0] CASTAGNOLI_POLY   = 32'h82F6_3B78;
  localparam int         SETTLE_CYCLES      = 30;

  typedef struct packed {
    logic        kind;
    logic [5:0]  slot;
    logic [63:0] bound;
    logic [15:0] tag;
    logic [7:0]  key_byte;
    logic        present;
    logic        last;
  } beat_t;

  typedef struct packed {
    logic        found;
    logic [5:0]  slot;
    logic [15:0] tag;
    logic [63:0] hash;
  } route_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_kind = 1'b0;
  logic [5:0]  in_slot_index = '0;
  logic [63:0] in_boundary_value = '0;
  logic [15:0] in_partition_tag = '0;
  logic [7:0]  in_key_byte = '0;
  logic        in_byte_present = 1'b0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_found;
  logic [5:0]  out_slot_found;
  logic [15:0] out_owner_tag;
  logic [63:0] out_key_hash;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  hash_partition_router_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_slot_index     (in_slot_index),
    .in_boundary_value (in_boundary_value),
    .in_partition_tag  (in_partition_tag),
    .in_key_byte       (in_key_byte),
    .in_byte_present   (in_byte_present),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_found         (out_found),
    .out_slot_found    (out_slot_found),
    .out_owner_tag     (out_owner_tag),
    .out_key_hash      (out_key_hash),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [63:0] bound_tbl [NUM_SLOTS];
  logic [15:0] tag_tbl [NUM_SLOTS];
  logic [31:0] crc_acc = 32'hFFFF_FFFF;
  logic [6:0]  entries_cfg = '0;
  route_t      pending_routes [$];

  int  errors = 0;
  int  items_sent = 0;
  int  burst_left = 0;
  int  hold_left = 0;
  int  stall_left = 0;
  bit  stall_lvl = 1'b0;
  bit  gaps_on = 1'b1;
  bit  stalls_on = 1'b1;

  function automatic logic [31:0] crc32c_update(logic [31:0] crc, logic [7:0] data);
    logic [31:0] r;
    logic        fb;
    r = crc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ data[i];
      r  = r >> 1;
      if (fb) r = r ^ CASTAGNOLI_POLY;
    end
    return r;
  endfunction

  function automatic int upper_bound_slot(logic [63:0] h, int n);
    int first;
    int count;
    int half;
    first = 0;
    count = n;
    while (count > 0) begin
      half = count / 2;
      if (bound_tbl[first + half] <= h) begin
        first = first + half + 1;
        count = count - half - 1;
      end else begin
        count = half;
      end
    end
    return first;
  endfunction

  task automatic route_beat(input beat_t b);
    logic [31:0] c;
    route_t      r;
    int          n;
    int          pos;
    if (b.kind == KIND_LOAD) begin
      bound_tbl[b.slot] = b.bound;
      tag_tbl[b.slot]   = b.tag;
    end else begin
      if (b.present) crc_acc = crc32c_update(crc_acc, b.key_byte);
      if (b.last) begin
        c       = ~crc_acc;
        crc_acc = 32'hFFFF_FFFF;
        n       = (entries_cfg > NUM_SLOTS) ? NUM_SLOTS : int'(entries_cfg);
        pos     = upper_bound_slot({c, c}, n);
        r.hash  = {c, c};
        if (pos < n) begin
          r.found = 1'b1;
          r.slot  = pos[5:0];
          r.tag   = tag_tbl[pos];
        end else begin
          r.found = 1'b0;
          r.slot  = '0;
          r.tag   = '0;
        end
        pending_routes = {pending_routes, r};
      end
    end
  endtask

  function automatic beat_t load_beat(logic [5:0] slot, logic [63:0] bound, logic [15:0] tag);
    beat_t b;
    b.kind     = KIND_LOAD;
    b.slot     = slot;
    b.bound    = bound;
    b.tag      = tag;
    b.key_byte = 8'($urandom_range(0, 255));
    b.present  = 1'($urandom_range(0, 1));
    b.last     = 1'($urandom_range(0, 1));
    return b;
  endfunction

  function automatic beat_t key_beat(logic [7:0] kb, logic present, logic last);
    beat_t b;
    b.kind     = KIND_KEY;
    b.slot     = 6'($urandom_range(0, 63));
    b.bound    = {$urandom, $urandom};
    b.tag      = 16'($urandom_range(0, 65535));
    b.key_byte = kb;
    b.present  = present;
    b.last     = last;
    return b;
  endfunction

  task automatic send_beat(input beat_t b);
    int gap;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
    in_valid          <= 1'b1;
    in_kind           <= b.kind;
    in_slot_index     <= b.slot;
    in_boundary_value <= b.bound;
    in_partition_tag  <= b.tag;
    in_key_byte       <= b.key_byte;
    in_byte_present   <= b.present;
    in_last_byte      <= b.last;
    do @(posedge clk); while (in_stall);
    route_beat(b);
    items_sent++;
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    while (pending_routes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_entries(input logic [6:0] v);
    settle_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_ENTRIES_IN_USE;
    pwdata  <= {25'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    entries_cfg = v;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {25'd0, v}) begin
      $display("%0t: entries_in_use readback expected %0d actual %0d", $time, v, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_random_load();
    int          s;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] v;
    s = $urandom_range(0, NUM_SLOTS - 1);
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      2, 3: v = {$urandom, $urandom};
      default: begin
        // keep the table sorted most of the time
        lo = (s == 0) ? 64'd0 : bound_tbl[s - 1];
        hi = (s == NUM_SLOTS - 1) ? '1 : bound_tbl[s + 1];
        v  = (hi > lo) ? lo + ({$urandom, $urandom} % (hi - lo)) : lo;
      end
    endcase
    send_beat(load_beat(6'(s), v, 16'($urandom_range(0, 65535))));
  endtask

  task automatic send_random_key();
    int len;
    bit absent_end;
    if ($urandom_range(0, 19) == 0) begin
      send_beat(key_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1));
      return;
    end
    len        = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
    absent_end = ($urandom_range(0, 7) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 11) == 0)
        send_beat(key_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0));
      if ($urandom_range(0, 11) == 0) send_random_load();
      send_beat(key_beat(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !absent_end));
    end
    if (absent_end) send_beat(key_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1));
  endtask

  task automatic random_traffic(input int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(0, 9) == 0) send_random_load();
      else send_random_key();
    end
  endtask

  task automatic load_sorted_table();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      send_beat(load_beat(6'(i), {6'(i), 26'($urandom_range(0, 32'h03FF_FFFF)), $urandom},
                          16'($urandom_range(0, 65535))));
    end
  endtask

  // ---- tests ----

  task automatic test_empty_table();
    set_entries(7'd0);
    send_beat(key_beat(8'h00, 1'b0, 1'b1));
    send_beat(key_beat(8'hA5, 1'b0, 1'b0));
    send_beat(key_beat(8'h00, 1'b1, 1'b1));
    send_beat(key_beat(8'hFF, 1'b1, 1'b1));
  endtask

  task automatic test_boundary_cases();
    // CRC-32C of "123456789" is E3069283
    send_beat(load_beat(6'd0, 64'd0, 16'h0000));
    send_beat(load_beat(6'd1, 64'hE306_9283_E306_9283, 16'hFFFF));
    send_beat(load_beat(6'd2, 64'hE306_9283_E306_9284, 16'h5A5A));
    send_beat(load_beat(6'd3, 64'hFFFF_FFFF_FFFF_FFFF, 16'hA5A5));
    send_beat(load_beat(6'd63, 64'h8000_0000_0000_0000, 16'h1234));
    set_entries(7'd4);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_beat(load_beat(6'd63, '1, 16'h0000));
      send_beat(key_beat(8'(8'h31 + i), 1'b1, i == 8));
    end
    send_beat(key_beat(8'h00, 1'b0, 1'b1));
    set_entries(7'd1);
    send_beat(key_beat(8'hFF, 1'b1, 1'b1));
  endtask

  task automatic test_full_table_lookup();
    load_sorted_table();
    set_entries(7'd64);
    random_traffic(300);
  endtask

  task automatic test_entry_counts();
    logic [6:0] counts [7];
    counts = '{7'd1, 7'd2, 7'd127, 7'd65, 7'd63, 7'd0, 7'd0};
    counts[6] = 7'($urandom_range(3, 62));
    foreach (counts[i]) begin
      set_entries(counts[i]);
      random_traffic(150);
    end
  endtask

  task automatic test_no_idle_stream();
    set_entries(7'd64);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    random_traffic(200);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  task automatic test_out_backpressure();
    gaps_on = 1'b0;
    hold_left <= 300;
    for (int i = 0; i < 40; i++) send_beat(key_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1));
    gaps_on = 1'b1;
    settle_idle();
  endtask

  task automatic test_reload_table();
    load_sorted_table();
    set_entries(7'd64);
    random_traffic(200);
  endtask

  // ---- result checking and output stall pattern ----

  task automatic check_route();
    route_t e;
    if (pending_routes.size() == 0) begin
      $display("%0t: unexpected result found=%0b slot=%0d tag=%h hash=%h", $time,
               out_found, out_slot_found, out_owner_tag, out_key_hash);
      errors++;
    end else begin
      e = pending_routes.pop_front();
      if (out_found !== e.found) begin
        $display("%0t: found expected %0b actual %0b", $time, e.found, out_found);
        errors++;
      end
      if (out_slot_found !== e.slot) begin
        $display("%0t: slot_found expected %0d actual %0d", $time, e.slot, out_slot_found);
        errors++;
      end
      if (out_owner_tag !== e.tag) begin
        $display("%0t: owner_tag expected %h actual %h", $time, e.tag, out_owner_tag);
        errors++;
      end
      if (out_key_hash !== e.hash) begin
        $display("%0t: key_hash expected %h actual %h", $time, e.hash, out_key_hash);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_route();
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!stalls_on) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_lvl  = ($urandom_range(0, 2) == 0);
        stall_left = $urandom_range(1, 7);
      end
      stall_left--;
      out_stall <= stall_lvl;
    end
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_boundary_cases();
    test_full_table_lookup();
    test_entry_counts();
    test_no_idle_stream();
    test_out_backpressure();
    test_reload_table();
    settle_idle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
